[src/rsch_pkg.sv]
// package: shared widths and constants for the ray segment closest hit core
`timescale 1ns / 1ps
`default_nettype none
package rsch_pkg;
    localparam int MAX_WALLS  = 64;
    localparam int SLOT_BITS  = 6;
    localparam int COORD_W    = 16;
    localparam int CNT_W      = 7;
    localparam int FRAC_W     = 17;
    localparam int DIFF_W     = COORD_W + 1;
    localparam int PROD_W     = 2 * DIFF_W;
    localparam int CROSS_W    = PROD_W + 1;
    localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_CAST  = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] sx;
        logic signed [COORD_W-1:0] sy;
        logic signed [COORD_W-1:0] ex;
        logic signed [COORD_W-1:0] ey;
    } t_wall;

    typedef struct packed {
        logic                      cmd;
        logic [SLOT_BITS-1:0]      wall_slot;
        logic signed [COORD_W-1:0] ax;
        logic signed [COORD_W-1:0] ay;
        logic signed [COORD_W-1:0] bx;
        logic signed [COORD_W-1:0] by;
    } t_in_beat;

    typedef struct packed {
        logic signed [COORD_W-1:0] hit_x;
        logic signed [COORD_W-1:0] hit_y;
        logic                      blocked;
        logic [FRAC_W-1:0]         nearest_fraction;
    } t_out_beat;
endpackage
`default_nettype wire

[src/rsch_if.sv]
// interface: valid/ready channel carrying one payload beat
`timescale 1ns / 1ps
`default_nettype none
interface rsch_if #(parameter type t_payload = logic);
    logic     valid;
    logic     ready;
    t_payload data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[src/ray_segment_closest_hit_core.sv]
// top level: wall table memory, per-wall cross products, fraction divider
//
// Write beats store one wall. A cast beat scans walls
// 0..min(wall_count,64)-1 out of a synchronous wall memory: each
// wall takes a read state, three cross-product stages and a 16-step
// restoring divider when it hits; after the scan the hit point is scaled
// in S_SC1 and S_SC2. The divider gives one quotient bit per cycle. The
// result sits in an output register; the next beat is taken once it is
// handed off.
`timescale 1ns / 1ps
`default_nettype none
module ray_segment_closest_hit_core
    import rsch_pkg::*;
(
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_cfg_we,
    input  wire [CNT_W-1:0]  i_cfg_data,
    rsch_if.sink             in_ch,
    rsch_if.source           out_ch
);
    localparam logic [3:0] S_IDLE = 4'd0, S_READ = 4'd1, S_LOAD = 4'd2,
                           S_MUL  = 4'd3, S_CHK = 4'd4, S_DIV = 4'd5,
                           S_SC1  = 4'd6, S_SC2 = 4'd7, S_OUT = 4'd8;

    logic [CNT_W-1:0]  r_count;
    logic [3:0]        r_state, n_state;
    logic [CNT_W-1:0]  r_idx, r_lim;
    t_wall             r_mem [MAX_WALLS];
    t_wall             r_rd;
    logic signed [COORD_W-1:0] r_ax, r_ay;
    logic signed [DIFF_W-1:0]  r_dx, r_dy;
    logic signed [DIFF_W-1:0]  r_wx, r_wy, r_qx, r_qy;
    logic signed [PROD_W-1:0]  r_p [6];
    logic signed [CROSS_W-1:0] r_det, r_nt, r_nu;
    logic [CROSS_W-1:0]        r_rem;
    logic [15:0]               r_f;
    logic [4:0]                r_step;
    logic [FRAC_W-1:0]         r_best;
    logic signed [DIFF_W+FRAC_W:0] r_mx, r_my;
    t_out_beat                 r_out;
    logic                      r_ovalid;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_data;
        end
    end

    assign in_ch.ready = (r_state == S_IDLE) && !r_ovalid;
    wire w_acc = in_ch.valid && in_ch.ready;

    // wall memory: write on write beats, registered read during scan
    always_ff @(posedge i_clk) begin
        if (w_acc && in_ch.data.cmd == CMD_WRITE) begin
            r_mem[in_ch.data.wall_slot] <= '{in_ch.data.ax, in_ch.data.ay,
                                             in_ch.data.bx, in_ch.data.by};
        end
        r_rd <= r_mem[r_idx[SLOT_BITS-1:0]];
    end

    // comparison terms after sign fix
    logic signed [CROSS_W-1:0] w_det, w_nt, w_nu;
    always_comb begin
        w_det = CROSS_W'(r_p[0]) - CROSS_W'(r_p[1]);
        w_nt  = CROSS_W'(r_p[2]) - CROSS_W'(r_p[3]);
        w_nu  = CROSS_W'(r_p[4]) - CROSS_W'(r_p[5]);
        if (w_det < 0) begin
            w_det = -w_det;
            w_nt  = -w_nt;
            w_nu  = -w_nu;
        end
    end

    logic [CROSS_W-1:0] w_sh;
    assign w_sh = {r_rem[CROSS_W-2:0], 1'b0};

    // scan sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_acc && in_ch.data.cmd == CMD_CAST) n_state = S_READ;
            S_READ: n_state = (r_idx >= r_lim) ? S_SC1 : S_LOAD;
            S_LOAD: n_state = S_MUL;
            S_MUL:  n_state = S_CHK;
            S_CHK:  n_state = (w_det != 0 && w_nt > 0 && w_nt < w_det && w_nu >= 0
                               && w_nu <= w_det) ? S_DIV : S_READ;
            S_DIV:  n_state = (r_step == 5'd15) ? S_READ : S_DIV;
            S_SC1:  n_state = S_SC2;
            S_SC2:  n_state = S_OUT;
            S_OUT:  n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_OUT) r_ovalid <= 1'b1;
            else if (out_ch.ready) r_ovalid <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_ax   <= in_ch.data.ax;
                r_ay   <= in_ch.data.ay;
                r_dx   <= DIFF_W'(in_ch.data.bx) - DIFF_W'(in_ch.data.ax);
                r_dy   <= DIFF_W'(in_ch.data.by) - DIFF_W'(in_ch.data.ay);
                r_idx  <= '0;
                r_lim  <= (r_count > CNT_W'(MAX_WALLS)) ? CNT_W'(MAX_WALLS) : r_count;
                r_best <= FRAC_ONE;
            end
            S_READ: r_idx <= r_idx + 1'b1;
            S_LOAD: begin
                r_wx <= DIFF_W'(r_rd.ex) - DIFF_W'(r_rd.sx);
                r_wy <= DIFF_W'(r_rd.ey) - DIFF_W'(r_rd.sy);
                r_qx <= DIFF_W'(r_rd.sx) - DIFF_W'(r_ax);
                r_qy <= DIFF_W'(r_rd.sy) - DIFF_W'(r_ay);
            end
            S_MUL: begin
                r_p[0] <= r_dx * r_wy;
                r_p[1] <= r_dy * r_wx;
                r_p[2] <= r_qx * r_wy;
                r_p[3] <= r_qy * r_wx;
                r_p[4] <= r_qx * r_dy;
                r_p[5] <= r_qy * r_dx;
            end
            S_CHK: begin
                r_det  <= w_det;
                r_rem  <= w_nt;
                r_f    <= '0;
                r_step <= '0;
            end
            S_DIV: begin
                r_step <= r_step + 1'b1;
                if (w_sh >= r_det) begin
                    r_rem <= w_sh - r_det;
                    r_f   <= {r_f[14:0], 1'b1};
                end else begin
                    r_rem <= w_sh;
                    r_f   <= {r_f[14:0], 1'b0};
                end
                if (r_step == 5'd15 &&
                    {1'b0, r_f[14:0], (w_sh >= r_det)} < r_best) begin
                    r_best <= {1'b0, r_f[14:0], (w_sh >= r_det)};
                end
            end
            S_SC1: begin
                r_mx <= r_dx * $signed({1'b0, r_best});
                r_my <= r_dy * $signed({1'b0, r_best});
            end
            S_SC2: begin
                r_out.hit_x <= r_ax + COORD_W'((r_mx + ((r_mx < 0) ? 35'sd65535 : 35'sd0))
                                               >>> 16);
                r_out.hit_y <= r_ay + COORD_W'((r_my + ((r_my < 0) ? 35'sd65535 : 35'sd0))
                                               >>> 16);
                r_out.blocked <= (r_best != FRAC_ONE);
                r_out.nearest_fraction <= r_best;
            end
            default: ;
        endcase
    end

    assign out_ch.valid = r_ovalid;
    assign out_ch.data  = r_out;

`ifndef SYNTH
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_ch.ready |-> (r_state == S_IDLE)) else $error("ready outside idle");
    a_best_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_best <= FRAC_ONE)) else $error("fraction out of range");
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && !out_ch.ready) |=> r_ovalid) else $error("result dropped");
    a_div_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_step <= 5'd15)) else $error("divider overrun");
`endif
endmodule
`default_nettype wire

[tb/sv/tb_ray_segment_closest_hit_core.sv]
// testbench: wall writes and ray casts checked against a closest-hit predictor
`timescale 1ns / 1ps
`default_nettype none
module tb_ray_segment_closest_hit_core;
    import rsch_pkg::*;

    localparam int CYCLE_LIMIT = 3000000;

    // one row of the directed stimulus table
    typedef struct {
        logic                 is_cfg;
        logic [CNT_W-1:0]     count;
        t_in_beat             beat;
        logic                 has_fixed;
        t_out_beat            fixed;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CNT_W-1:0] i_cfg_data;

    rsch_if #(.t_payload(t_in_beat))  in_ch ();
    rsch_if #(.t_payload(t_out_beat)) out_ch ();

    ray_segment_closest_hit_core dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .in_ch      (in_ch.sink),
        .out_ch     (out_ch.source)
    );

    // predictor state
    t_wall            walls [MAX_WALLS];
    logic [CNT_W-1:0] count_model;
    t_out_beat        hit_queue [$];
    int               error_count;
    longint           cycle_count;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // run watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // nearest wall hit along the ray from a to b
    function automatic t_out_beat closest_hit(t_in_beat c);
        t_out_beat r;
        longint dx, dy, wx, wy, qx, qy, det, nt, nu, rem;
        longint best, f, n;
        dx = longint'(c.bx) - longint'(c.ax);
        dy = longint'(c.by) - longint'(c.ay);
        n = (count_model < MAX_WALLS) ? count_model : MAX_WALLS;
        best = 65536;
        for (int i = 0; i < n; i++) begin
            wx = longint'(walls[i].ex) - longint'(walls[i].sx);
            wy = longint'(walls[i].ey) - longint'(walls[i].sy);
            qx = longint'(walls[i].sx) - longint'(c.ax);
            qy = longint'(walls[i].sy) - longint'(c.ay);
            det = dx * wy - dy * wx;
            nt = qx * wy - qy * wx;
            nu = qx * dy - qy * dx;
            if (det != 0) begin
                if (det < 0) begin
                    det = -det; nt = -nt; nu = -nu;
                end
                if (nt > 0 && nt < det && nu >= 0 && nu <= det) begin
                    rem = nt;
                    f = 0;
                    for (int k = 0; k < 16; k++) begin
                        rem = rem << 1;
                        f = f << 1;
                        if (rem >= det) begin
                            rem = rem - det;
                            f = f | 1;
                        end
                    end
                    if (f < best) best = f;
                end
            end
        end
        r.hit_x = 16'(longint'(c.ax) + (dx * best) / 65536);
        r.hit_y = 16'(longint'(c.ay) + (dy * best) / 65536);
        r.blocked = (best < 65536);
        r.nearest_fraction = FRAC_W'(best);
        return r;
    endfunction

    // update table or queue the expected cast result
    function automatic void accept_beat(t_in_beat b);
        if (b.cmd == CMD_WRITE) begin
            walls[b.wall_slot] = '{b.ax, b.ay, b.bx, b.by};
        end else begin
            hit_queue.push_back(closest_hit(b));
        end
    endfunction

    // output side: random stalls and field checks
    initial begin
        int stall;
        out_ch.ready = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 3) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                   : $urandom_range(1, 3);
                out_ch.ready = 1'b0;
                repeat (stall) @(negedge i_clk);
            end
            out_ch.ready = 1'b1;
        end
    end

    always @(posedge i_clk) begin
        t_out_beat e;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (hit_queue.size() == 0) begin
                $error("result beat with nothing expected");
                error_count++;
            end else begin
                e = hit_queue.pop_front();
                if (out_ch.data.hit_x !== e.hit_x) begin
                    $error("hit_x expected %0d actual %0d", e.hit_x, out_ch.data.hit_x);
                    error_count++;
                end
                if (out_ch.data.hit_y !== e.hit_y) begin
                    $error("hit_y expected %0d actual %0d", e.hit_y, out_ch.data.hit_y);
                    error_count++;
                end
                if (out_ch.data.blocked !== e.blocked) begin
                    $error("blocked expected %0d actual %0d", e.blocked,
                           out_ch.data.blocked);
                    error_count++;
                end
                if (out_ch.data.nearest_fraction !== e.nearest_fraction) begin
                    $error("nearest_fraction expected %0d actual %0d",
                           e.nearest_fraction, out_ch.data.nearest_fraction);
                    error_count++;
                end
            end
        end
    end

    // send one beat, sometimes after a random gap; valid stays up for the next call
    task automatic send_beat(t_in_beat b);
        int gap;
        if ($urandom_range(0, 2) == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                             : $urandom_range(1, 3);
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.data <= b;
        in_ch.valid <= 1'b1;
        do @(posedge i_clk); while (!in_ch.ready);
        accept_beat(b);
        @(negedge i_clk);
    endtask

    // drain, then write the wall count while idle
    task automatic set_count(logic [CNT_W-1:0] v);
        in_ch.valid <= 1'b0;
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (20) @(negedge i_clk);
        i_cfg_data <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        count_model = v;
    endtask

    function automatic logic signed [15:0] rand_coord(int mode);
        case (mode)
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return 16'($signed($urandom_range(0, 4000)) - 2000);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_in_beat rand_wall(int slot);
        t_in_beat b;
        int m;
        m = $urandom_range(0, 9);
        b.cmd = CMD_WRITE;
        b.wall_slot = SLOT_BITS'(slot);
        b.ax = rand_coord(m < 7 ? 2 : $urandom_range(0, 3));
        b.ay = rand_coord(m < 7 ? 2 : $urandom_range(0, 3));
        b.bx = rand_coord(m < 7 ? 2 : $urandom_range(0, 3));
        b.by = rand_coord(m < 7 ? 2 : $urandom_range(0, 3));
        if (m == 9) begin
            b.bx = b.ax;
            b.by = b.ay;
        end
        return b;
    endfunction

    function automatic t_in_beat rand_cast();
        t_in_beat b;
        int m;
        m = $urandom_range(0, 9);
        b = rand_wall(0);
        b.cmd = CMD_CAST;
        b.wall_slot = SLOT_BITS'($urandom);
        if (m < 6) begin
            b.ax = rand_coord(2); b.ay = rand_coord(2);
            b.bx = rand_coord(2); b.by = rand_coord(2);
        end
        return b;
    endfunction

    // directed table and random phases
    initial begin
        t_row table_rows [$];
        t_row r;
        t_out_beat got;
        int limit;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.data = '0;
        error_count = 0;
        cycle_count = 0;
        count_model = '0;
        foreach (walls[i]) walls[i] = '0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // cast with no walls gives the target; extremes of the coordinates
        r = '{1'b0, '0, '{CMD_CAST, 6'h3f, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh7fff},
              1'b1, '{16'sh7fff, 16'sh7fff, 1'b0, FRAC_ONE}};
        table_rows.push_back(r);
        r = '{1'b0, '0, '{CMD_CAST, 6'h00, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff},
              1'b1, '{16'sh8000, 16'sh7fff, 1'b0, FRAC_ONE}};
        table_rows.push_back(r);
        // vertical wall at x=16 from y=-160..160, slot 0
        r = '{1'b0, '0, '{CMD_WRITE, 6'd0, 16'sd16, -16'sd160, 16'sd16, 16'sd160},
              1'b0, '0};
        table_rows.push_back(r);
        // parallel wall, slot 1
        r = '{1'b0, '0, '{CMD_WRITE, 6'd1, 16'sd0, 16'sd32, 16'sd64, 16'sd32}, 1'b0, '0};
        table_rows.push_back(r);
        // degenerate wall, slot 2; extreme wall, slot 63
        r = '{1'b0, '0, '{CMD_WRITE, 6'd2, 16'sd5, 16'sd5, 16'sd5, 16'sd5}, 1'b0, '0};
        table_rows.push_back(r);
        r = '{1'b0, '0, '{CMD_WRITE, 6'd63, 16'sh8000, 16'sh7fff, 16'sh7fff, 16'sh8000},
              1'b0, '0};
        table_rows.push_back(r);
        for (int s = 3; s < 63; s++) begin
            r = '{1'b0, '0, rand_wall(s), 1'b0, '0};
            table_rows.push_back(r);
        end
        r = '{1'b1, 7'd3, '0, 1'b0, '0};
        table_rows.push_back(r);
        // ray from 0 to x=32 hits at half
        r = '{1'b0, '0, '{CMD_CAST, 6'd0, 16'sd0, 16'sd0, 16'sd32, 16'sd0},
              1'b1, '{16'sd16, 16'sd0, 1'b1, 17'h08000}};
        table_rows.push_back(r);
        // ray ending exactly on the wall: no hit
        r = '{1'b0, '0, '{CMD_CAST, 6'd0, 16'sd0, 16'sd0, 16'sd16, 16'sd0},
              1'b1, '{16'sd16, 16'sd0, 1'b0, FRAC_ONE}};
        table_rows.push_back(r);
        // zero-length ray
        r = '{1'b0, '0, '{CMD_CAST, 6'd0, 16'sd7, 16'sd7, 16'sd7, 16'sd7},
              1'b1, '{16'sd7, 16'sd7, 1'b0, FRAC_ONE}};
        table_rows.push_back(r);
        // hit very near the origin
        r = '{1'b0, '0, '{CMD_CAST, 6'd0, 16'sd15, 16'sd0, 16'sh7fff, 16'sd0},
              1'b0, '0};
        table_rows.push_back(r);
        r = '{1'b1, 7'd127, '0, 1'b0, '0};
        table_rows.push_back(r);
        r = '{1'b0, '0, '{CMD_CAST, 6'd0, 16'sh8000, 16'sd0, 16'sh7fff, 16'sd0},
              1'b0, '0};
        table_rows.push_back(r);
        r = '{1'b0, '0, '{CMD_CAST, 6'd0, 16'sd0, 16'sh8000, 16'sd0, 16'sh7fff},
              1'b0, '0};
        table_rows.push_back(r);

        foreach (table_rows[i]) begin
            if (table_rows[i].is_cfg) begin
                set_count(table_rows[i].count);
            end else begin
                if (table_rows[i].has_fixed && table_rows[i].beat.cmd == CMD_CAST) begin
                    got = closest_hit(table_rows[i].beat);
                    if (got !== table_rows[i].fixed) begin
                        $error("table row %0d disagrees with predictor", i);
                        error_count++;
                    end
                end
                send_beat(table_rows[i].beat);
            end
        end

        // random phases, each with its own wall count
        for (int p = 0; p < 8; p++) begin
            case (p)
                0: limit = 0;
                1: limit = 1;
                2: limit = 64;
                3: limit = 100;
                default: limit = $urandom_range(2, 12);
            endcase
            set_count(CNT_W'(limit));
            for (int k = 0; k < 230; k++) begin
                if ($urandom_range(0, 3) == 0)
                    send_beat(rand_wall($urandom_range(0, 63)));
                else
                    send_beat(rand_cast());
            end
        end

        in_ch.valid <= 1'b0;
        while (hit_queue.size() != 0) @(negedge i_clk);
        repeat (400) @(negedge i_clk);
        if (error_count == 0 && hit_queue.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end
endmodule
`default_nettype wire

[ray_segment_closest_hit_core.f]
src/rsch_pkg.sv
src/rsch_if.sv
src/ray_segment_closest_hit_core.sv
tb/sv/tb_ray_segment_closest_hit_core.sv
